// ----- hdl/wbp_pkg.sv -----
// shared types, constants and float compare for the wkb bounding box parser
package wbp_pkg;

  localparam int unsigned MAX_NESTING_DEF = 8;

  // parse phases
  typedef enum logic [2:0] {
    PH_ORDER, PH_TYPE, PH_NPTS, PH_NRINGS, PH_NMEMB, PH_X, PH_Y, PH_DONE
  } phase_t;

  // result status codes
  localparam logic [1:0] ST_COMPLETE  = 2'd0;
  localparam logic [1:0] ST_CUT_SHORT = 2'd1;
  localparam logic [1:0] ST_TOO_DEEP  = 2'd2;

  // geometry type codes (low byte of the type word)
  localparam logic [7:0] TYPE_MASK   = 8'hFF;
  localparam logic [7:0] GT_POINT    = 8'd1;
  localparam logic [7:0] GT_LINE     = 8'd2;
  localparam logic [7:0] GT_POLYGON  = 8'd3;
  localparam logic [7:0] GT_MULTI_LO = 8'd4;
  localparam logic [7:0] GT_MULTI_HI = 8'd7;

  // field lengths in bytes
  localparam logic [3:0] HEADER_BYTES = 4'd5;
  localparam logic [3:0] COUNT_BYTES  = 4'd4;
  localparam logic [3:0] COORD_BYTES  = 4'd8;

  localparam logic [63:0] POS_INF = 64'h7FF0000000000000;
  localparam logic [63:0] NEG_INF = 64'hFFF0000000000000;

  typedef struct packed {
    logic [63:0] min_x;
    logic [63:0] min_y;
    logic [63:0] max_x;
    logic [63:0] max_y;
  } box_t;

  // ieee double a < b, false on nan, signed zeros equal
  function automatic logic fp_lt(input logic [63:0] a, input logic [63:0] b);
    logic a_nan;
    logic b_nan;
    logic zeros;
    logic res;
    a_nan = (a[62:52] == 11'h7FF) && (a[51:0] != 52'd0);
    b_nan = (b[62:52] == 11'h7FF) && (b[51:0] != 52'd0);
    zeros = (a[62:0] == 63'd0) && (b[62:0] == 63'd0);
    if (a_nan || b_nan || zeros) begin
      res = 1'b0;
    end else if (a[63] != b[63]) begin
      res = a[63];
    end else if (!a[63]) begin
      res = a[62:0] < b[62:0];
    end else begin
      res = a[62:0] > b[62:0];
    end
    return res;
  endfunction

endpackage

// ----- hdl/wbp_channels.sv -----
// valid/ready channel interfaces for the byte input and the box result
interface wbp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;
  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

interface wbp_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] min_x;
  logic [63:0] min_y;
  logic [63:0] max_x;
  logic [63:0] max_y;
  logic [1:0]  parse_status;
  modport source (output valid, output min_x, output min_y, output max_x,
                  output max_y, output parse_status, input ready);
  modport sink (input valid, input min_x, input min_y, input max_x,
                input max_y, input parse_status, output ready);
endinterface

// ----- hdl/wbp_bound_update.sv -----
// widens the running bounding box by one point using ieee double compares
module wbp_bound_update (
  input  wbp_pkg::box_t       box_in,
  input  logic                pt_valid,
  input  logic [63:0]         pt_x,
  input  logic [63:0]         pt_y,
  output wbp_pkg::box_t       box_out
);
  import wbp_pkg::*;

  // each bound moves only on a strict compare
  always_comb begin
    box_out = box_in;
    if (pt_valid) begin
      if (fp_lt(pt_x, box_in.min_x)) box_out.min_x = pt_x;
      if (fp_lt(pt_y, box_in.min_y)) box_out.min_y = pt_y;
      if (fp_lt(box_in.max_x, pt_x)) box_out.max_x = pt_x;
      if (fp_lt(box_in.max_y, pt_y)) box_out.max_y = pt_y;
    end
  end

endmodule

// ----- hdl/wkb_bounding_box_parser_unit.sv -----
// top level: byte-serial wkb geometry parser producing a 2d bounding box
// Takes one byte of a well-known-binary geometry record per cycle while the
// input is ready, and returns one result (min_x, min_y, max_x, max_y as
// double bit patterns, plus a status) for the request with last_byte. Each
// byte is parsed combinationally: field assembly, the open-collection stack
// and one double compare per bound sit between the parse registers, so the
// sustained rate is one byte per cycle unless a held result stalls it. The
// result lands in an output register in the cycle after the last byte; the
// next record is held off while it waits unaccepted. Collections nest up to
// MAX_NESTING deep; the member stack keeps a count and a "last member" flag
// per level, so closing any number of levels is a single stack write.
module wkb_bounding_box_parser_unit #(
  parameter int unsigned MAX_NESTING = wbp_pkg::MAX_NESTING_DEF
) (
  input logic       clk,
  input logic       rst_n,
  wbp_in_if.sink    in_ch,
  wbp_out_if.source out_ch
);
  import wbp_pkg::*;

  localparam int unsigned LW = $clog2(MAX_NESTING + 1);
  localparam int unsigned IW = (MAX_NESTING > 1) ? $clog2(MAX_NESTING) : 1;

  phase_t       phase_r, phase_nxt;
  logic [63:0]  shift_r, shift_nxt;
  logic [2:0]   fbytes_r, fbytes_nxt;
  logic         swap_r, swap_nxt;
  logic [31:0]  pts_r, pts_nxt;
  logic [31:0]  rings_r, rings_nxt;
  logic [63:0]  hx_r, hx_nxt;
  logic [LW-1:0] level_r, level_nxt;
  logic         deep_r, deep_nxt;
  box_t         box_r, box_nxt;
  logic [31:0]  stk_cnt_r [MAX_NESTING];
  logic [MAX_NESTING-1:0] stk_one_r;

  logic         out_valid_r;
  box_t         out_box_r;
  logic [1:0]   out_status_r;
  logic [1:0]   status_nxt;

  logic         in_acc;
  logic [7:0]   b;
  logic [63:0]  field_val;
  logic [3:0]   need;
  logic         field_done;
  logic [31:0]  cnt_val;

  logic         fin_found;
  logic [IW-1:0] fin_idx;
  logic [31:0]  fin_cnt;
  logic         do_fin;

  logic         stk_we;
  logic [IW-1:0] stk_wa;
  logic [31:0]  stk_wd;

  logic         pt_valid;
  box_t         box_upd;

  assign in_acc = in_ch.valid && in_ch.ready;
  assign b      = in_ch.data_byte;

  // result register frees the input side when empty or being drained
  always_comb begin
    in_ch.ready         = !out_valid_r || out_ch.ready;
    out_ch.valid        = out_valid_r;
    out_ch.min_x        = out_box_r.min_x;
    out_ch.min_y        = out_box_r.min_y;
    out_ch.max_x        = out_box_r.max_x;
    out_ch.max_y        = out_box_r.max_y;
    out_ch.parse_status = out_status_r;
  end

  // field assembly in either byte order
  always_comb begin
    unique case (phase_r)
      PH_TYPE:  need = HEADER_BYTES - 4'd1;
      PH_X, PH_Y: need = COORD_BYTES;
      default:  need = COUNT_BYTES;
    endcase
    if (swap_r) begin
      field_val = {shift_r[55:0], b};
    end else begin
      field_val = shift_r | ({56'd0, b} << {fbytes_r, 3'b000});
    end
    field_done = ({1'b0, fbytes_r} + 4'd1) >= need;
    cnt_val    = field_val[31:0];
  end

  // deepest open collection that still has members after this one
  always_comb begin
    fin_found = 1'b0;
    fin_idx   = '0;
    for (int i = 0; i < MAX_NESTING; i++) begin
      if ((LW'(i) < level_r) && !stk_one_r[i]) begin
        fin_found = 1'b1;
        fin_idx   = IW'(i);
      end
    end
    fin_cnt = stk_cnt_r[fin_idx];
  end

  // next parse state
  always_comb begin
    phase_nxt  = phase_r;
    shift_nxt  = shift_r;
    fbytes_nxt = fbytes_r;
    swap_nxt   = swap_r;
    pts_nxt    = pts_r;
    rings_nxt  = rings_r;
    hx_nxt     = hx_r;
    level_nxt  = level_r;
    deep_nxt   = deep_r;
    do_fin     = 1'b0;
    pt_valid   = 1'b0;
    stk_we     = 1'b0;
    stk_wa     = level_r[IW-1:0];
    stk_wd     = cnt_val;

    if (phase_r != PH_ORDER && phase_r != PH_DONE) begin
      if (field_done) begin
        shift_nxt  = '0;
        fbytes_nxt = '0;
      end else begin
        shift_nxt  = field_val;
        fbytes_nxt = fbytes_r + 3'd1;
      end
    end

    unique case (phase_r)
      PH_ORDER: begin
        swap_nxt   = (b == 8'd0);
        shift_nxt  = '0;
        fbytes_nxt = '0;
        phase_nxt  = PH_TYPE;
      end
      PH_TYPE: begin
        if (field_done) begin
          priority if ((field_val[7:0] & TYPE_MASK) == GT_POINT) begin
            rings_nxt = '0;
            pts_nxt   = 32'd1;
            phase_nxt = PH_X;
          end else if ((field_val[7:0] & TYPE_MASK) == GT_LINE) begin
            rings_nxt = 32'd1;
            phase_nxt = PH_NPTS;
          end else if ((field_val[7:0] & TYPE_MASK) == GT_POLYGON) begin
            phase_nxt = PH_NRINGS;
          end else if ((field_val[7:0] & TYPE_MASK) >= GT_MULTI_LO &&
                       (field_val[7:0] & TYPE_MASK) <= GT_MULTI_HI) begin
            phase_nxt = PH_NMEMB;
          end else begin
            do_fin = 1'b1;
          end
        end
      end
      PH_NRINGS: begin
        if (field_done) begin
          if (cnt_val == 32'd0) begin
            do_fin = 1'b1;
          end else begin
            rings_nxt = cnt_val;
            phase_nxt = PH_NPTS;
          end
        end
      end
      PH_NPTS: begin
        if (field_done) begin
          rings_nxt = rings_r - {31'd0, (rings_r != 32'd0)};
          if (cnt_val != 32'd0) begin
            pts_nxt   = cnt_val;
            phase_nxt = PH_X;
          end else if (rings_nxt != 32'd0) begin
            phase_nxt = PH_NPTS;
          end else begin
            do_fin = 1'b1;
          end
        end
      end
      PH_NMEMB: begin
        if (field_done) begin
          if (cnt_val == 32'd0) begin
            do_fin = 1'b1;
          end else if (level_r >= LW'(MAX_NESTING)) begin
            deep_nxt  = 1'b1;
            phase_nxt = PH_DONE;
          end else begin
            stk_we    = 1'b1;
            level_nxt = level_r + LW'(1);
            phase_nxt = PH_ORDER;
          end
        end
      end
      PH_X: begin
        if (field_done) begin
          hx_nxt    = field_val;
          phase_nxt = PH_Y;
        end
      end
      PH_Y: begin
        if (field_done) begin
          pt_valid = 1'b1;
          pts_nxt  = pts_r - {31'd0, (pts_r != 32'd0)};
          if (pts_nxt != 32'd0) begin
            phase_nxt = PH_X;
          end else if (rings_r != 32'd0) begin
            phase_nxt = PH_NPTS;
          end else begin
            do_fin = 1'b1;
          end
        end
      end
      PH_DONE: begin
        phase_nxt = PH_DONE;
      end
      default: begin
        phase_nxt = PH_DONE;
      end
    endcase

    // geometry finished: step to next member or close the whole tree
    if (do_fin) begin
      if (fin_found) begin
        stk_we    = 1'b1;
        stk_wa    = fin_idx;
        stk_wd    = fin_cnt - 32'd1;
        level_nxt = LW'(fin_idx) + LW'(1);
        phase_nxt = PH_ORDER;
      end else begin
        level_nxt = '0;
        phase_nxt = PH_DONE;
      end
    end
  end

  wbp_bound_update u_bound (
    .box_in   (box_r),
    .pt_valid (pt_valid),
    .pt_x     (hx_r),
    .pt_y     (field_val),
    .box_out  (box_upd)
  );

  assign box_nxt = box_upd;

  // status of a record ending on this byte
  always_comb begin
    priority if (deep_nxt) begin
      status_nxt = ST_TOO_DEEP;
    end else if (phase_nxt != PH_DONE) begin
      status_nxt = ST_CUT_SHORT;
    end else begin
      status_nxt = ST_COMPLETE;
    end
  end

  // parse state, cleared at the end of each record
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_ORDER;
      shift_r  <= '0;
      fbytes_r <= '0;
      swap_r   <= 1'b0;
      pts_r    <= '0;
      rings_r  <= '0;
      hx_r     <= '0;
      level_r  <= '0;
      deep_r   <= 1'b0;
      box_r    <= '{POS_INF, POS_INF, NEG_INF, NEG_INF};
    end else if (in_acc) begin
      if (in_ch.last_byte) begin
        phase_r  <= PH_ORDER;
        shift_r  <= '0;
        fbytes_r <= '0;
        swap_r   <= 1'b0;
        pts_r    <= '0;
        rings_r  <= '0;
        hx_r     <= '0;
        level_r  <= '0;
        deep_r   <= 1'b0;
        box_r    <= '{POS_INF, POS_INF, NEG_INF, NEG_INF};
      end else begin
        phase_r  <= phase_nxt;
        shift_r  <= shift_nxt;
        fbytes_r <= fbytes_nxt;
        swap_r   <= swap_nxt;
        pts_r    <= pts_nxt;
        rings_r  <= rings_nxt;
        hx_r     <= hx_nxt;
        level_r  <= level_nxt;
        deep_r   <= deep_nxt;
        box_r    <= box_nxt;
      end
    end
  end

  // member stack: remaining count and a last-member flag per level
  always_ff @(posedge clk) begin
    if (in_acc && stk_we) begin
      stk_cnt_r[stk_wa] <= stk_wd;
      stk_one_r[stk_wa] <= (stk_wd == 32'd1);
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_acc && in_ch.last_byte) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && in_ch.last_byte) begin
      out_box_r    <= box_nxt;
      out_status_r <= status_nxt;
    end
  end

`ifndef SYNTHESIS
  a_level_range: assert property (@(posedge clk) disable iff (!rst_n)
    level_r <= LW'(MAX_NESTING))
    else $error("nesting level beyond limit");

  a_last_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_ch.last_byte) |=> out_valid_r)
    else $error("last byte gave no result");

  a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_ch.last_byte) |=> (phase_r == PH_ORDER && level_r == '0 && !deep_r))
    else $error("parse state not cleared after record");

  a_deep_done: assert property (@(posedge clk) disable iff (!rst_n)
    deep_r |-> phase_r == PH_DONE)
    else $error("parsing continued after nesting overflow");
`endif

endmodule

// ----- dv/wkb_bounding_box_parser_unit_test.sv -----
// testbench for the wkb bounding box parser: directed and random records checked against a built-in predictor
module wkb_bounding_box_parser_unit_test;
  timeunit 1ns;
  timeprecision 1ps;
  import wbp_pkg::*;

  localparam int unsigned NEST = MAX_NESTING_DEF;
  localparam int unsigned CYCLE_LIMIT = 400000;

  // expected box and status of one record
  typedef struct packed {
    box_t       box;
    logic [1:0] status;
  } envelope_t;

  // keeps predicted envelopes and counts mismatches
  class envelope_scoreboard;
    envelope_t pending[$];
    int unsigned mismatches;

    function void note_request(envelope_t e);
      pending.push_back(e);
    endfunction

    function void check_result(envelope_t got);
      envelope_t want;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h", got);
        return;
      end
      want = pending.pop_front();
      if (got.box.min_x !== want.box.min_x || got.box.min_y !== want.box.min_y ||
          got.box.max_x !== want.box.max_x || got.box.max_y !== want.box.max_y ||
          got.status !== want.status) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: expected %h %h %h %h st %0d, got %h %h %h %h st %0d",
                   want.box.min_x, want.box.min_y, want.box.max_x, want.box.max_y,
                   want.status, got.box.min_x, got.box.min_y, got.box.max_x,
                   got.box.max_y, got.status);
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  wbp_in_if  in_ch();
  wbp_out_if out_ch();

  wkb_bounding_box_parser_unit dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source)
  );

  envelope_scoreboard board;
  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  bit hold_off;
  int unsigned cycles;

  // predictor state
  box_t        pr_box;
  phase_t      pr_phase;
  logic [63:0] pr_shift;
  int unsigned pr_nbytes;
  bit          pr_swap;
  logic [31:0] pr_points;
  logic [31:0] pr_rings;
  logic [63:0] pr_held_x;
  logic [31:0] pr_members[NEST];
  int unsigned pr_level;
  bit          pr_too_deep;

  // byte stream of one record under construction
  logic [7:0] rec[$];

  // ieee double a < b on bit patterns
  function automatic bit dbl_less(logic [63:0] a, logic [63:0] b);
    bit a_nan;
    bit b_nan;
    a_nan = (a[62:52] == 11'h7FF) && (a[51:0] != 0);
    b_nan = (b[62:52] == 11'h7FF) && (b[51:0] != 0);
    if (a_nan || b_nan) return 0;
    if (a[62:0] == 0 && b[62:0] == 0) return 0;
    if (a[63] != b[63]) return a[63];
    if (!a[63]) return a[62:0] < b[62:0];
    return a[62:0] > b[62:0];
  endfunction

  task automatic envelope_clear();
    pr_box = '{min_x: POS_INF, min_y: POS_INF, max_x: NEG_INF, max_y: NEG_INF};
    pr_phase = PH_ORDER;
    pr_shift = 0;
    pr_nbytes = 0;
    pr_swap = 0;
    pr_points = 0;
    pr_rings = 0;
    pr_held_x = 0;
    pr_level = 0;
    pr_too_deep = 0;
    foreach (pr_members[i]) pr_members[i] = 0;
  endtask

  // collect one field byte; returns 1 with the value once complete
  function automatic bit field_gather(logic [7:0] b, int unsigned need,
                                      output logic [63:0] v);
    if (pr_swap) pr_shift = (pr_shift << 8) | 64'(b);
    else pr_shift = pr_shift | (64'(b) << (8 * (pr_nbytes & 7)));
    if (pr_nbytes + 1 >= need) begin
      v = pr_shift;
      pr_shift = 0;
      pr_nbytes = 0;
      return 1;
    end
    pr_nbytes++;
    return 0;
  endfunction

  function automatic void geometry_done();
    forever begin
      if (pr_level == 0) begin
        pr_phase = PH_DONE;
        return;
      end
      pr_members[pr_level-1]--;
      if (pr_members[pr_level-1] == 0) begin
        pr_level--;
        continue;
      end
      pr_phase = PH_ORDER;
      return;
    end
  endfunction

  function automatic void points_done();
    if (pr_rings > 0) pr_phase = PH_NPTS;
    else geometry_done();
  endfunction

  // advance the predictor by one byte
  task automatic envelope_step(logic [7:0] b, bit last);
    logic [63:0] v;
    envelope_t e;
    case (pr_phase)
      PH_ORDER: begin
        pr_swap = (b == 0);
        pr_shift = 0;
        pr_nbytes = 0;
        pr_phase = PH_TYPE;
      end
      PH_TYPE: if (field_gather(b, 4, v)) begin
        if (v[7:0] == GT_POINT) begin
          pr_rings = 0;
          pr_points = 1;
          pr_phase = PH_X;
        end else if (v[7:0] == GT_LINE) begin
          pr_rings = 1;
          pr_phase = PH_NPTS;
        end else if (v[7:0] == GT_POLYGON) begin
          pr_phase = PH_NRINGS;
        end else if (v[7:0] >= GT_MULTI_LO && v[7:0] <= GT_MULTI_HI) begin
          pr_phase = PH_NMEMB;
        end else begin
          geometry_done();
        end
      end
      PH_NRINGS: if (field_gather(b, 4, v)) begin
        if (v[31:0] == 0) geometry_done();
        else begin
          pr_rings = v[31:0];
          pr_phase = PH_NPTS;
        end
      end
      PH_NPTS: if (field_gather(b, 4, v)) begin
        if (pr_rings > 0) pr_rings--;
        if (v[31:0] == 0) points_done();
        else begin
          pr_points = v[31:0];
          pr_phase = PH_X;
        end
      end
      PH_NMEMB: if (field_gather(b, 4, v)) begin
        if (v[31:0] == 0) geometry_done();
        else if (pr_level >= NEST) begin
          pr_too_deep = 1;
          pr_phase = PH_DONE;
        end else begin
          pr_members[pr_level] = v[31:0];
          pr_level++;
          pr_phase = PH_ORDER;
        end
      end
      PH_X: if (field_gather(b, 8, v)) begin
        pr_held_x = v;
        pr_phase = PH_Y;
      end
      PH_Y: if (field_gather(b, 8, v)) begin
        if (dbl_less(pr_held_x, pr_box.min_x)) pr_box.min_x = pr_held_x;
        if (dbl_less(v, pr_box.min_y)) pr_box.min_y = v;
        if (dbl_less(pr_box.max_x, pr_held_x)) pr_box.max_x = pr_held_x;
        if (dbl_less(pr_box.max_y, v)) pr_box.max_y = v;
        if (pr_points > 0) pr_points--;
        if (pr_points > 0) pr_phase = PH_X;
        else points_done();
      end
      default: pr_phase = PH_DONE;
    endcase
    if (last) begin
      e.box = pr_box;
      e.status = pr_too_deep ? ST_TOO_DEEP :
                 (pr_phase != PH_DONE) ? ST_CUT_SHORT : ST_COMPLETE;
      board.note_request(e);
      envelope_clear();
    end
  endtask

  // record builders
  function automatic void put_word(logic [63:0] v, int unsigned n, bit big);
    for (int i = 0; i < n; i++)
      rec.push_back(big ? v[8*(n-1-i) +: 8] : v[8*i +: 8]);
  endfunction

  function automatic logic [63:0] rand_coord();
    logic [63:0] c;
    c = {$urandom, $urandom};
    case ($urandom_range(0, 9))
      0: c = 64'h7FF8000000000000 | c[51:0];
      1: c = c[63] ? NEG_INF : POS_INF;
      2: c = {c[63], 63'd0};
      3, 4, 5: c = {c[63], 1'b1, 6'd0, c[55:0]};
      default: ;
    endcase
    return c;
  endfunction

  function automatic void put_header(logic [7:0] gtype, bit big);
    logic [31:0] t;
    t = {$urandom_range(0, 1) ? $urandom : 32'd0};
    t[7:0] = gtype;
    rec.push_back(big ? 8'd0 : 8'($urandom_range(1, 255)));
    put_word(64'(t), 4, big);
  endfunction

  function automatic void put_geometry(int unsigned depth, bit deep_ok);
    bit big;
    int unsigned kind;
    int unsigned n;
    big = $urandom_range(0, 1);
    kind = $urandom_range(0, 9);
    if (deep_ok && depth < NEST + 1) kind = 9;
    if (depth > 3 && !deep_ok && kind >= 7) kind = 0;
    case (kind)
      0, 1: begin
        put_header(GT_POINT, big);
        put_word(rand_coord(), 8, big);
        put_word(rand_coord(), 8, big);
      end
      2, 3: begin
        put_header(GT_LINE, big);
        n = $urandom_range(0, 4);
        put_word(64'(n), 4, big);
        repeat (2 * n) put_word(rand_coord(), 8, big);
      end
      4, 5: begin
        put_header(GT_POLYGON, big);
        n = $urandom_range(0, 3);
        put_word(64'(n), 4, big);
        repeat (n) begin
          int unsigned p;
          p = $urandom_range(0, 3);
          put_word(64'(p), 4, big);
          repeat (2 * p) put_word(rand_coord(), 8, big);
        end
      end
      6: put_header(8'($urandom_range(8, 255)) | 8'($urandom_range(0, 1) ? 0 : 0), big);
      default: begin
        put_header(8'($urandom_range(GT_MULTI_LO, GT_MULTI_HI)), big);
        n = deep_ok ? 1 : $urandom_range(0, 3);
        put_word(64'(n), 4, big);
        repeat (n) put_geometry(depth + 1, deep_ok);
      end
    endcase
  endfunction

  // send one byte, waiting for acceptance
  task automatic send_byte(logic [7:0] b, bit last);
    while (send_idle_pct != 0 && $urandom_range(1, 100) <= send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data_byte <= b;
    in_ch.last_byte <= last;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    envelope_step(b, last);
  endtask

  // send the built record; optionally cut short or with trailing noise
  task automatic send_record(int unsigned style);
    int unsigned len;
    if (style == 1 && rec.size() > 1) rec = rec[0:$urandom_range(0, rec.size() - 2)];
    if (style == 2) repeat ($urandom_range(1, 4)) rec.push_back(8'($urandom));
    len = rec.size();
    for (int i = 0; i < len; i++) send_byte(rec[i], i == len - 1);
    rec.delete();
  endtask

  task automatic random_record();
    int unsigned r;
    r = $urandom_range(0, 19);
    if (r == 0) begin
      repeat ($urandom_range(1, 30)) rec.push_back(8'($urandom));
      send_record(0);
    end else begin
      put_geometry(0, r == 1);
      send_record(r < 4 ? 1 : (r < 6 ? 2 : 0));
    end
  endtask

  // stop offering requests and wait for every result
  task automatic drain();
    in_ch.valid <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // clock
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // watchdog
  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles >= CYCLE_LIMIT) begin
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  // result side: random stalls, a long hold-off on request, compare on accept
  initial begin
    envelope_t got;
    out_ch.ready = 1'b0;
    @(posedge clk);
    forever begin
      out_ch.ready <= !hold_off &&
                      !(recv_stall_pct != 0 && $urandom_range(1, 100) <= recv_stall_pct);
      @(posedge clk);
      if (rst_n && out_ch.valid && out_ch.ready) begin
        got.box = '{out_ch.min_x, out_ch.min_y, out_ch.max_x, out_ch.max_y};
        got.status = out_ch.parse_status;
        board.check_result(got);
      end
    end
  end

  // stimulus
  initial begin
    board = new();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_off = 0;
    envelope_clear();
    in_ch.valid = 1'b0;
    in_ch.data_byte = 8'd0;
    in_ch.last_byte = 1'b0;
    rst_n = 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: single-byte record, each type, extreme bytes, too deep, cut short
    rec.push_back(8'hFF);
    send_record(0);
    put_header(GT_POINT, 1);
    put_word(64'h8000000000000000, 8, 1);
    put_word(64'h0000000000000000, 8, 1);
    send_record(0);
    put_header(GT_POINT, 0);
    put_word(64'hFFFFFFFFFFFFFFFF, 8, 0);
    put_word(64'h7FEFFFFFFFFFFFFF, 8, 0);
    send_record(2);
    put_header(8'hFF, 1);
    send_record(0);
    put_header(GT_LINE, 0);
    put_word(0, 4, 0);
    send_record(0);
    put_header(GT_POLYGON, 1);
    put_word(0, 4, 1);
    send_record(0);
    put_header(GT_MULTI_HI, 0);
    put_word(0, 4, 0);
    send_record(0);
    put_geometry(0, 1);
    send_record(0);
    put_header(GT_POLYGON, 0);
    put_word(2, 4, 0);
    put_word(1, 4, 0);
    put_word(64'h3FF0000000000000, 8, 0);
    put_word(64'hC000000000000000, 8, 0);
    send_record(1);
    drain();

    // random phases with different idling
    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct = (ph == 1 || ph == 3) ? (ph == 1 ? 68 : 38) : 0;
      recv_stall_pct = (ph == 2 || ph == 3) ? (ph == 2 ? 68 : 38) : 0;
      repeat (ph == 0 ? 5 : 4) random_record();
    end

    // hold the result side off while records keep coming
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_off = 1;
    fork
      begin
        int unsigned held;
        held = 0;
        while (held < 300) begin
          @(posedge clk);
          held++;
        end
        hold_off = 0;
      end
      repeat (3) random_record();
    join
    drain();

    if (board.mismatches == 0 && board.pending.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
